// ===== hw/rtl/nrsh_pkg.sv =====
// Shared types, constants and helper functions for the nearest ray-sphere hit block.
// Used by the top level, the iterative shift-subtract unit and the multiplier.
package nrsh_pkg;

  localparam int MAX_SPHERES_DEF = 1024;
  localparam logic [31:0] RADIUS_SQ_RESET = 32'd65536;
  // Squared length at or below this (LSB 2^-32) is a segment of length <= 0.0001.
  localparam logic [63:0] SHORT_L2_MAX = 64'd42;

  localparam int MUL_W = 35;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ENTRY_W = 97;   // valid bit and three 32-bit centre coordinates

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  // The one unused code; such items are dropped without a result.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS = 6'd48;
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  typedef enum logic {
    ITER_SQRT = 1'b0,
    ITER_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (!v[35] && (v[34:31] != 4'h0)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[35] && (v[34:31] != 4'hF)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/nearest_ray_sphere_hit.sv =====
// Nearest ray-sphere hit over a table of MAX_SPHERES centres of one radius, Q16.16.
// One shared multiplier and one shared shift-subtract unit (square root, division) do all
// the arithmetic, and the square root per valid entry dominates a query. One query is in
// work at a time. After reset a clearing pass empties the table; input is stalled
// meanwhile, configuration writes are taken.
module nearest_ray_sphere_hit #(
  parameter int MAX_SPHERES = nrsh_pkg::MAX_SPHERES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_start_z,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_end_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [9:0]         out_hit_index,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import nrsh_pkg::*;

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(MAX_SPHERES + 1);

  typedef enum logic [20:0] {
    ST_CLEAR = 21'h000001,
    ST_IDLE  = 21'h000002,
    ST_L2M   = 21'h000004,
    ST_L2A   = 21'h000008,
    ST_L2CHK = 21'h000010,
    ST_LSQ   = 21'h000020,
    ST_DIVS  = 21'h000040,
    ST_DIVW  = 21'h000080,
    ST_RD    = 21'h000100,
    ST_CHK   = 21'h000200,
    ST_DOTM  = 21'h000400,
    ST_DOTA  = 21'h000800,
    ST_WWM   = 21'h001000,
    ST_WWA   = 21'h002000,
    ST_BBM   = 21'h004000,
    ST_BBA   = 21'h008000,
    ST_RT    = 21'h010000,
    ST_FIN   = 21'h020000,
    ST_HPM   = 21'h040000,
    ST_HPA   = 21'h080000,
    ST_DONE  = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] s_r [3];
  logic signed [31:0] s_nxt [3];
  logic signed [31:0] d_r [3];
  logic signed [31:0] d_nxt [3];
  logic signed [17:0] u_r [3];
  logic signed [17:0] u_nxt [3];
  logic signed [31:0] w_r [3];
  logic signed [31:0] w_nxt [3];
  logic signed [31:0] hp_r [3];
  logic signed [31:0] hp_nxt [3];
  logic [63:0]        acc_r, acc_nxt;
  logic [31:0]        len_r, len_nxt;
  logic signed [33:0] b_r, b_nxt;
  logic signed [32:0] nearest_r, nearest_nxt;
  logic [AW-1:0]      best_r, best_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      walk_r, walk_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [31:0]        rad_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [9:0]         out_idx_r, out_idx_nxt;
  logic signed [31:0] out_x_r, out_x_nxt;
  logic signed [31:0] out_y_r, out_y_nxt;
  logic signed [31:0] out_z_r, out_z_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  iter_req_t                iter_req;
  logic [63:0]              iter_opa;
  logic [31:0]              iter_opb;
  logic                     iter_done;
  logic [47:0]              iter_res;

  logic [31:0]        idx_ext;
  logic [31:0]        best_ext;
  logic               load_ok;
  logic               k_last;
  logic [63:0]        sum64;
  logic [63:0]        a_val;
  logic [31:0]        absd;
  logic signed [35:0] nb, rt, t1, t_val;
  logic signed [35:0] hv;
  logic               keep;

  nrsh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SPHERES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  nrsh_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  nrsh_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .opa   (iter_opa),
    .opb   (iter_opb),
    .done  (iter_done),
    .res   (iter_res)
  );

  assign idx_ext  = {22'd0, in_entry_index};
  assign load_ok  = (idx_ext < 32'(MAX_SPHERES));
  assign best_ext = 32'(best_r);
  assign k_last   = (k_r == 2'd2);
  assign sum64    = acc_r + mul_p[63:0];
  assign a_val    = mul_p[63:0] + {16'd0, rad_r, 16'd0};
  assign absd     = d_r[k_r][31] ? (~d_r[k_r] + 32'd1) : d_r[k_r];
  assign nb       = 36'sd0 - {{2{b_r[33]}}, b_r};
  assign rt       = {4'd0, iter_res[31:0]};
  assign t1       = nb - rt;
  // The near root lies behind the start: take the far root instead.
  assign t_val    = t1[35] ? (nb + rt) : t1;
  assign keep     = !t_val[35] && (t_val <= {{3{nearest_r[32]}}, nearest_r});
  assign hv       = {mul_p[50], mul_p[50:16]};

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    hp_nxt        = hp_r;
    acc_nxt       = acc_r;
    len_nxt       = len_r;
    b_nxt         = b_r;
    nearest_nxt   = nearest_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    walk_nxt      = walk_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_idx_nxt   = out_idx_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    ram_we        = 1'b0;
    ram_waddr     = walk_r[AW-1:0];
    ram_wdata     = '0;
    mul_a         = '0;
    mul_b         = '0;
    iter_req      = '{start: 1'b0, op: ITER_SQRT};
    iter_opa      = acc_r;
    iter_opb      = len_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (walk_r == CW'(MAX_SPHERES - 1)) begin
          walk_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = walk_r + CW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_WRITE, KIND_CLEAR: begin
              ram_we    = load_ok;
              ram_waddr = idx_ext[AW-1:0];
              ram_wdata = {(in_kind == KIND_WRITE), in_centre_x, in_centre_y, in_centre_z};
            end
            KIND_QUERY: begin
              s_nxt[0]  = in_start_x;
              s_nxt[1]  = in_start_y;
              s_nxt[2]  = in_start_z;
              d_nxt[0]  = sat32(sx36(in_end_x) - sx36(in_start_x));
              d_nxt[1]  = sat32(sx36(in_end_y) - sx36(in_start_y));
              d_nxt[2]  = sat32(sx36(in_end_z) - sx36(in_start_z));
              acc_nxt   = '0;
              k_nxt     = 2'd0;
              state_nxt = ST_L2M;
            end
            default: begin
            end
          endcase
        end
      end
      ST_L2M: begin
        mul_a     = {{3{d_r[k_r][31]}}, d_r[k_r]};
        mul_b     = {{3{d_r[k_r][31]}}, d_r[k_r]};
        state_nxt = ST_L2A;
      end
      ST_L2A: begin
        acc_nxt = sum64;
        if (k_last) begin
          k_nxt     = 2'd0;
          state_nxt = ST_L2CHK;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_L2M;
        end
      end
      ST_L2CHK: begin
        if (acc_r <= SHORT_L2_MAX) begin
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          iter_req  = '{start: 1'b1, op: ITER_SQRT};
          state_nxt = ST_LSQ;
        end
      end
      ST_LSQ: begin
        if (iter_done) begin
          len_nxt   = iter_res[31:0];
          k_nxt     = 2'd0;
          state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        iter_req  = '{start: 1'b1, op: ITER_DIV};
        iter_opa  = {16'd0, absd, 16'd0};
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (iter_done) begin
          // Truncation toward zero: divide magnitudes, then restore the sign.
          if (d_r[k_r][31]) begin
            u_nxt[k_r] = 18'sd0 - {1'b0, iter_res[16:0]};
          end else begin
            u_nxt[k_r] = {1'b0, iter_res[16:0]};
          end
          if (k_last) begin
            walk_nxt    = '0;
            nearest_nxt = {1'b0, len_r};
            found_nxt   = 1'b0;
            state_nxt   = ST_RD;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_DIVS;
          end
        end
      end
      ST_RD: begin
        if (walk_r == CW'(MAX_SPHERES)) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!ram_rdata[ENTRY_W-1]) begin
          walk_nxt  = walk_r + CW'(1);
          state_nxt = ST_RD;
        end else begin
          w_nxt[0]  = sat32(sx36(s_r[0]) - sx36(ram_rdata[95:64]));
          w_nxt[1]  = sat32(sx36(s_r[1]) - sx36(ram_rdata[63:32]));
          w_nxt[2]  = sat32(sx36(s_r[2]) - sx36(ram_rdata[31:0]));
          acc_nxt   = '0;
          k_nxt     = 2'd0;
          state_nxt = ST_DOTM;
        end
      end
      ST_DOTM: begin
        mul_a     = {{3{w_r[k_r][31]}}, w_r[k_r]};
        mul_b     = {{17{u_r[k_r][17]}}, u_r[k_r]};
        state_nxt = ST_DOTA;
      end
      ST_DOTA: begin
        if (k_last) begin
          b_nxt     = sum64[49:16];
          acc_nxt   = '0;
          k_nxt     = 2'd0;
          state_nxt = ST_WWM;
        end else begin
          acc_nxt   = sum64;
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_DOTM;
        end
      end
      ST_WWM: begin
        mul_a     = {{3{w_r[k_r][31]}}, w_r[k_r]};
        mul_b     = {{3{w_r[k_r][31]}}, w_r[k_r]};
        state_nxt = ST_WWA;
      end
      ST_WWA: begin
        acc_nxt = sum64;
        if (k_last) begin
          k_nxt     = 2'd0;
          state_nxt = ST_BBM;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_WWM;
        end
      end
      ST_BBM: begin
        mul_a     = {b_r[33], b_r};
        mul_b     = {b_r[33], b_r};
        state_nxt = ST_BBA;
      end
      ST_BBA: begin
        if (a_val < acc_r) begin
          walk_nxt  = walk_r + CW'(1);
          state_nxt = ST_RD;
        end else begin
          iter_req  = '{start: 1'b1, op: ITER_SQRT};
          iter_opa  = a_val - acc_r;
          state_nxt = ST_RT;
        end
      end
      ST_RT: begin
        if (iter_done) begin
          // An equal t still replaces the earlier entry.
          if (keep) begin
            nearest_nxt = t_val[32:0];
            best_nxt    = walk_r[AW-1:0];
            found_nxt   = 1'b1;
          end
          walk_nxt  = walk_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        k_nxt = 2'd0;
        if (found_r) begin
          state_nxt = ST_HPM;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_HPM: begin
        mul_a     = {{17{u_r[k_r][17]}}, u_r[k_r]};
        mul_b     = {{2{nearest_r[32]}}, nearest_r};
        state_nxt = ST_HPA;
      end
      ST_HPA: begin
        hp_nxt[k_r] = sat32(sx36(s_r[k_r]) + hv);
        if (k_last) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_HPM;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = found_r;
          if (found_r) begin
            out_idx_nxt = best_ext[9:0];
            out_x_nxt   = hp_r[0];
            out_y_nxt   = hp_r[1];
            out_z_nxt   = hp_r[2];
          end else begin
            out_idx_nxt = '0;
            out_x_nxt   = '0;
            out_y_nxt   = '0;
            out_z_nxt   = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rad_r       <= RADIUS_SQ_RESET;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        rad_r <= cfg_data;
      end
    end
    s_r       <= s_nxt;
    d_r       <= d_nxt;
    u_r       <= u_nxt;
    w_r       <= w_nxt;
    hp_r      <= hp_nxt;
    acc_r     <= acc_nxt;
    len_r     <= len_nxt;
    b_r       <= b_nxt;
    nearest_r <= nearest_nxt;
    best_r    <= best_nxt;
    k_r       <= k_nxt;
    out_hit_r <= out_hit_nxt;
    out_idx_r <= out_idx_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_z_r   <= out_z_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_index = out_idx_r;
  assign out_hit_x     = out_x_r;
  assign out_hit_y     = out_y_r;
  assign out_hit_z     = out_z_r;

endmodule

// ===== hw/rtl/nrsh_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module nrsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/nrsh_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nrsh_pkg for the operand width.
module nrsh_mul (
  input  logic                               clk,
  input  logic signed [nrsh_pkg::MUL_W-1:0]  a,
  input  logic signed [nrsh_pkg::MUL_W-1:0]  b,
  output logic signed [nrsh_pkg::PROD_W-1:0] p
);
  import nrsh_pkg::*;

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== hw/rtl/nrsh_iter.sv =====
// Iterative shift-subtract unit: 64-bit integer square root (two bits a step)
// or 48-by-32 unsigned restoring division (one bit a step). Depends on nrsh_pkg.
module nrsh_iter (
  input  logic                clk,
  input  logic                rst_n,
  input  nrsh_pkg::iter_req_t req,
  input  logic [63:0]         opa,
  input  logic [31:0]         opb,
  output logic                done,
  output logic [47:0]         res
);
  import nrsh_pkg::*;

  logic [63:0] x_r, x_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [31:0] divisor_r, divisor_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  iter_op_t    op_r, op_nxt;
  logic [63:0] trial_sq;
  logic [33:0] trial_dv;
  logic        dv_ge;

  always_comb begin
    x_nxt       = x_r;
    res_nxt     = res_r;
    bit_nxt     = bit_r;
    divisor_nxt = divisor_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    done_nxt    = 1'b0;
    trial_sq    = res_r + bit_r;
    trial_dv    = {x_r[32:0], res_r[63]};
    dv_ge       = (trial_dv >= {2'b00, divisor_r});

    if (req.start) begin
      op_nxt      = req.op;
      divisor_nxt = opb;
      unique case (req.op)
        ITER_SQRT: begin
          x_nxt   = opa;
          res_nxt = '0;
          bit_nxt = SQRT_BIT0;
          cnt_nxt = SQRT_STEPS;
        end
        ITER_DIV: begin
          x_nxt   = '0;
          res_nxt = {opa[47:0], 16'h0000};
          cnt_nxt = DIV_STEPS;
        end
      endcase
    end else if (cnt_r != 6'd0) begin
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
      unique case (op_r)
        ITER_SQRT: begin
          if (x_r >= trial_sq) begin
            x_nxt   = x_r - trial_sq;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
        ITER_DIV: begin
          // The dividend shifts out at the top while quotient bits shift in below.
          if (dv_ge) begin
            x_nxt = {30'd0, trial_dv - {2'b00, divisor_r}};
          end else begin
            x_nxt = {30'd0, trial_dv};
          end
          res_nxt = {res_r[62:0], dv_ge};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      op_r   <= ITER_SQRT;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    x_r       <= x_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    divisor_r <= divisor_nxt;
  end

  assign done = done_r;
  assign res  = res_r[47:0];

endmodule

// ===== hw/rtl/nrsh_chk.sv =====
// Port-level checker for the nearest ray-sphere hit block, bound to the top level.
// Watches only top-level ports; depends on nrsh_pkg for the item kind codes.
module nrsh_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [9:0]  out_hit_index,
  input logic [31:0] out_hit_x,
  input logic [31:0] out_hit_y,
  input logic [31:0] out_hit_z
);
  import nrsh_pkg::*;

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_hit_index)
      && $stable(out_hit_x) && $stable(out_hit_y) && $stable(out_hit_z))
    else $error("result changed while stalled");

  // A query occupies the block, so input is stalled on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_QUERY) |=> in_stall)
    else $error("input taken right after a query");

  // A miss reports zero index and point.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_hit_index == 10'd0) && (out_hit_x == 32'd0)
      && (out_hit_y == 32'd0) && (out_hit_z == 32'd0))
    else $error("miss with nonzero fields");

  // The table clearing pass holds off input right after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

endmodule

bind nearest_ray_sphere_hit nrsh_chk u_nrsh_chk (.*);

// ===== tb/sv/nrsh_checker.sv =====
// Checker for the nearest ray-sphere hit block: tracks the sphere table and radius,
// predicts one result per accepted query and compares the results that come out.
// Depends on nrsh_pkg for the item kind codes.
`timescale 1ns / 100ps

module nrsh_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_start_z,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_end_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic [9:0]         out_hit_index,
  input  logic signed [31:0] out_hit_x,
  input  logic signed [31:0] out_hit_y,
  input  logic signed [31:0] out_hit_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 fails,
  output int                 pending,
  output int                 results_seen,
  output int                 hits_seen
);
  import nrsh_pkg::*;

  localparam int TABLE_DEPTH = MAX_SPHERES_DEF;

  typedef struct {
    bit                 hit;
    logic [9:0]         index;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } hit_rec_t;

  logic signed [31:0] tab_x [TABLE_DEPTH];
  logic signed [31:0] tab_y [TABLE_DEPTH];
  logic signed [31:0] tab_z [TABLE_DEPTH];
  bit                 tab_used [TABLE_DEPTH];
  logic [31:0]        radius_sq;
  hit_rec_t           expected_hits [$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned square(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    return m * m;
  endfunction

  // Bitwise integer square root, rounded down.
  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic hit_rec_t nearest_hit(logic signed [31:0] s_in [3],
                                           logic signed [31:0] e_in [3]);
    hit_rec_t          rec;
    longint            s [3];
    longint            d [3];
    longint            u [3];
    longint            w [3];
    longint unsigned   l2, len, ww, a, root;
    longint            nearest, dot, b, t;
    int                best;
    rec = '{hit: 0, index: '0, px: '0, py: '0, pz: '0};
    l2 = 0;
    for (int k = 0; k < 3; k++) begin
      s[k] = longint'(s_in[k]);
      d[k] = clip32(longint'(e_in[k]) - s[k]);
      l2 += square(d[k]);
    end
    if (l2 <= 64'd42) return rec;
    len = root64(l2);
    for (int k = 0; k < 3; k++) u[k] = (d[k] * 65536) / longint'(len);
    nearest = longint'(len);
    best = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tab_used[i]) continue;
      w[0] = clip32(s[0] - longint'(tab_x[i]));
      w[1] = clip32(s[1] - longint'(tab_y[i]));
      w[2] = clip32(s[2] - longint'(tab_z[i]));
      dot = w[0] * u[0] + w[1] * u[1] + w[2] * u[2];
      b = dot >>> 16;
      ww = square(w[0]) + square(w[1]) + square(w[2]);
      a = square(b) + (longint'(radius_sq) << 16);
      if (a < ww) continue;
      root = root64(a - ww);
      // Take the far root when the near one lies behind the start.
      t = -b - longint'(root);
      if (t < 0) t = -b + longint'(root);
      if (t < 0 || t > nearest) continue;
      nearest = t;
      best = i;
    end
    if (best >= 0) begin
      rec.hit = 1;
      rec.index = best[9:0];
      rec.px = 32'(clip32(s[0] + ((u[0] * nearest) >>> 16)));
      rec.py = 32'(clip32(s[1] + ((u[1] * nearest) >>> 16)));
      rec.pz = 32'(clip32(s[2] + ((u[2] * nearest) >>> 16)));
    end
    return rec;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    hit_rec_t           want;
    logic signed [31:0] sv [3];
    logic signed [31:0] ev [3];
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tab_used[i] = 0;
      radius_sq = 32'd65536;
      expected_hits.delete();
    end else begin
      if (cfg_valid && cfg_ready) radius_sq = cfg_data;
      if (in_valid && !in_stall) begin
        unique case (in_kind)
          KIND_WRITE: begin
            tab_x[in_entry_index] = in_centre_x;
            tab_y[in_entry_index] = in_centre_y;
            tab_z[in_entry_index] = in_centre_z;
            tab_used[in_entry_index] = 1;
          end
          KIND_CLEAR: tab_used[in_entry_index] = 0;
          KIND_QUERY: begin
            sv = '{in_start_x, in_start_y, in_start_z};
            ev = '{in_end_x, in_end_y, in_end_z};
            expected_hits.insert(expected_hits.size(), nearest_hit(sv, ev));
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_hits.size() == 0) begin
          $display("[%0t] result item arrived with nothing expected", $time);
          fails++;
        end else begin
          want = expected_hits.pop_front();
          if (want.hit) hits_seen++;
          if (out_hit !== want.hit) report("hit", out_hit, want.hit);
          if (out_hit_index !== want.index) report("hit_index", out_hit_index, want.index);
          if (out_hit_x !== want.px) report("hit_x", out_hit_x, want.px);
          if (out_hit_y !== want.py) report("hit_y", out_hit_y, want.py);
          if (out_hit_z !== want.pz) report("hit_z", out_hit_z, want.pz);
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

// ===== tb/sv/tb_nearest_ray_sphere_hit.sv =====
// Top of the nearest ray-sphere hit testbench: clock, reset, item stimulus, radius
// writes and the verdict. Depends on nrsh_pkg, the block and nrsh_checker.
`timescale 1ns / 100ps

module tb_nearest_ray_sphere_hit;
  import nrsh_pkg::*;

  localparam int  ONE = 65536;
  localparam int  CYCLE_LIMIT = 8_000_000;
  localparam int  HOLD_CYCLES = 9000;
  localparam int  PHASE_ITEMS = 130;

  logic               clk = 0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_kind;
  logic [9:0]         in_entry_index;
  logic signed [31:0] in_centre_x, in_centre_y, in_centre_z;
  logic signed [31:0] in_start_x, in_start_y, in_start_z;
  logic signed [31:0] in_end_x, in_end_y, in_end_z;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic [9:0]         out_hit_index;
  logic signed [31:0] out_hit_x, out_hit_y, out_hit_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;

  int fails, pending, results_seen, hits_seen;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  int ball_x [32], ball_y [32], ball_z [32];

  always #5 clk = ~clk;

  nearest_ray_sphere_hit DUT (.*);

  nrsh_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        repeat (HOLD_CYCLES) begin
          out_stall <= 1;
          @(posedge clk);
        end
        hold_taken = 1;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic int near_units(int span);
    return $urandom_range(2 * span * ONE) - span * ONE;
  endfunction

  task automatic send_item(logic [1:0] kind, int idx,
                           int cx, int cy, int cz,
                           int sx, int sy, int sz, int ex, int ey, int ez);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_entry_index <= 10'(idx);
    in_centre_x <= cx;
    in_centre_y <= cy;
    in_centre_z <= cz;
    in_start_x <= sx;
    in_start_y <= sy;
    in_start_z <= sz;
    in_end_x <= ex;
    in_end_y <= ey;
    in_end_z <= ez;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_radius(logic [31:0] value);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // A load or an ignored item may still be settling.
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic random_item();
    int pick, slot, ox, oy, oz;
    pick = $urandom_range(99);
    slot = $urandom_range(31);
    if (pick < 30) begin
      // Segment aimed through a known sphere, with some jitter.
      ox = near_units(8);
      oy = near_units(8);
      oz = near_units(8);
      send_item(KIND_QUERY, $urandom, $urandom, $urandom, $urandom,
                ball_x[slot] + ox, ball_y[slot] + oy, ball_z[slot] + oz,
                ball_x[slot] - ox + near_units(1), ball_y[slot] - oy + near_units(1),
                ball_z[slot] - oz + near_units(1));
    end else if (pick < 38) begin
      send_item(KIND_QUERY, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 66) begin
      ball_x[slot] = near_units(12);
      ball_y[slot] = near_units(12);
      ball_z[slot] = near_units(12);
      send_item(KIND_WRITE, slot, ball_x[slot], ball_y[slot], ball_z[slot],
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 71) begin
      send_item(KIND_WRITE, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 97) begin
      send_item(KIND_CLEAR, (pick < 90) ? slot : $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_item(KIND_SPARE, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_phase(int idle_pct, int stall_pct, logic [31:0] radius);
    write_radius(radius);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) random_item();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_kind = KIND_WRITE;
    in_entry_index = '0;
    {in_centre_x, in_centre_y, in_centre_z} = '0;
    {in_start_x, in_start_y, in_start_z} = '0;
    {in_end_x, in_end_y, in_end_z} = '0;
    cfg_valid = 0;
    cfg_data = '0;
    for (int i = 0; i < 32; i++) begin
      ball_x[i] = near_units(12);
      ball_y[i] = near_units(12);
      ball_z[i] = near_units(12);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed part at the reset radius of one unit.
    send_item(KIND_WRITE, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_WRITE, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              0, 0, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0, -5 * ONE, 0, 0, 5 * ONE, 0, 0);
    // Start inside the sphere, so the far root is taken.
    send_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 5 * ONE, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE);
    send_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 6, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 7, 0, 0);
    // Differences that saturate in every component, then large coordinates that do not.
    send_item(KIND_QUERY, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 0, 0, 0, 0, 32'h7FFF_0000, 32'h7FFF_0000, 32'h8001_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    // Two spheres at one place: the higher index wins the tie.
    send_item(KIND_WRITE, 10'd5, 10 * ONE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_WRITE, 10'd6, 10 * ONE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0, 10 * ONE, -5 * ONE, 0, 10 * ONE, 5 * ONE, 0);
    send_item(KIND_CLEAR, 10'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0, 10 * ONE, -5 * ONE, 0, 10 * ONE, 5 * ONE, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0, 0, 20 * ONE, 0, 5 * ONE, 20 * ONE, 0);
    // Sphere behind the start, then a segment that stops short of one.
    send_item(KIND_QUERY, 0, 0, 0, 0, 5 * ONE, 0, 0, 8 * ONE, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0, -10 * ONE, 0, 0, -5 * ONE, 0, 0);
    send_item(KIND_SPARE, 10'd1023, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_item(KIND_CLEAR, 10'd1023, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_CLEAR, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_CLEAR, 10'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    random_phase(0, 0, 32'd262144);
    random_phase(75, 0, 32'hFFFF_FFFF);
    random_phase(0, 75, 32'd0);
    random_phase(8, 8, 32'd65536 + $urandom_range(15 * ONE));

    // Long receiver hold-off while queries keep coming, so the input backs up.
    write_radius(32'd1048576);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1;
    for (int i = 0; i < 12; i++) begin
      send_item(KIND_QUERY, 0, 0, 0, 0, ball_x[i] - 6 * ONE, ball_y[i], ball_z[i],
                ball_x[i] + 6 * ONE, ball_y[i], ball_z[i]);
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d items over five stall settings and six radius values.", items_sent);
    $display("Checked %0d result items, %0d of them hits.", results_seen, hits_seen);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
